// ===== rtl/core/crcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// CRC-16 checked frame parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

    localparam int MAX_PAYLOAD = 512;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] FRAME_OVH = 16'd9;
    localparam logic [15:0] TOTAL_MAX = 16'(MAX_PAYLOAD) + FRAME_OVH;

    localparam logic [7:0] HEAD_RESET = 8'h50;
    localparam logic [7:0] TAIL_RESET = 8'h43;

    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 10;
    localparam int CIDX_W  = 8;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_HEAD_FIRST  = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_HEAD_SECOND = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_TAIL_FIRST  = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_TAIL_SECOND = 8'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD_OK,
        PH_HEAD_BAD,
        PH_LEN,
        PH_CMD,
        PH_PAYLOAD,
        PH_CRC,
        PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_CRC    = 3'd2,
        ST_TAIL   = 3'd3,
        ST_LENGTH = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] head_first;
        logic [BYTE_W-1:0] head_second;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        t_status           status;
        logic [PLEN_W-1:0] plen;
        logic              done;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crcfp_if.sv =====
// ----------------------------------------------------------------------------
// crcfp channel interfaces
// Valid/ready channels for received bytes, parse results and register writes.
// ----------------------------------------------------------------------------
interface crcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface crcfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [9:0] payload_len;
    logic       frame_done;

    modport source (output valid, out_kind, out_byte, status, payload_len, frame_done,
                    input ready);
    modport sink   (input valid, out_kind, out_byte, status, payload_len, frame_done,
                    output ready);
endinterface

interface crcfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/crcfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crcfp_cfg_regs
// Header and tail match registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module crcfp_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    crcfp_cfg_if.sink       i_cfg,
    output crcfp_pkg::t_cfg o_cfg
);
    import crcfp_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_first  <= HEAD_RESET;
            r_cfg.head_second <= HEAD_RESET;
            r_cfg.tail_first  <= TAIL_RESET;
            r_cfg.tail_second <= TAIL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HEAD_FIRST:  r_cfg.head_first  <= i_cfg.data;
                CFG_HEAD_SECOND: r_cfg.head_second <= i_cfg.data;
                CFG_TAIL_FIRST:  r_cfg.tail_first  <= i_cfg.data;
                CFG_TAIL_SECOND: r_cfg.tail_second <= i_cfg.data;
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

endmodule

// ===== rtl/core/crcfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// crcfp_in_stage
// Input register for one received byte; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module crcfp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    crcfp_in_if.sink            i_in,
    input  logic                i_take,
    output logic                o_valid,
    output crcfp_pkg::t_in_item o_item
);
    import crcfp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.rx_byte     <= i_in.rx_byte;
            r_item.frame_start <= i_in.frame_start;
        end
    end

endmodule

// ===== rtl/core/crcfp_parser.sv =====
// ----------------------------------------------------------------------------
// crcfp_parser
// Frame state machine with the one-byte CRC update; state advances on i_take.
// ----------------------------------------------------------------------------
module crcfp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  crcfp_pkg::t_in_item i_item,
    input  crcfp_pkg::t_cfg     i_cfg,
    output logic                o_res_valid,
    output crcfp_pkg::t_result  o_res
);
    import crcfp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [PLEN_W-1:0] r_pos,   n_pos;
    logic [15:0]       r_total, n_total;
    logic [15:0]       r_crc,   n_crc;
    logic [7:0]        r_crc_hi, n_crc_hi;
    logic              r_crc_bad, n_crc_bad;
    logic              r_tail_ok, n_tail_ok;

    logic [15:0]       total_diff;
    logic [PLEN_W-1:0] psize;
    logic [PLEN_W-1:0] pos_inc;
    logic [7:0]        rx;

    assign rx         = i_item.rx_byte;
    assign total_diff = r_total - FRAME_OVH;
    assign psize      = total_diff[PLEN_W-1:0];
    assign pos_inc    = r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_total   <= '0;
            r_crc     <= CRC_INIT;
            r_crc_hi  <= '0;
            r_crc_bad <= 1'b0;
            r_tail_ok <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_total   <= n_total;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
            r_crc_bad <= n_crc_bad;
            r_tail_ok <= n_tail_ok;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_total     = r_total;
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        n_crc_bad   = r_crc_bad;
        n_tail_ok   = r_tail_ok;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_STATUS, data: '0, status: ST_OK, plen: '0, done: 1'b1};

        if (i_item.frame_start) begin
            // close a frame cut short by a new start
            if (r_phase != PH_IDLE) begin
                o_res_valid = 1'b1;
                o_res.status = ST_LENGTH;
                if (r_phase == PH_PAYLOAD) begin
                    o_res.plen = r_pos;
                end else if (r_phase == PH_CRC || r_phase == PH_TAIL) begin
                    o_res.plen = psize;
                end
            end
            n_crc     = CRC_INIT;
            n_pos     = '0;
            n_total   = '0;
            n_crc_hi  = '0;
            n_crc_bad = 1'b0;
            n_tail_ok = 1'b0;
            n_phase   = (rx == i_cfg.head_first) ? PH_HEAD_OK : PH_HEAD_BAD;
        end else begin
            case (r_phase)
                PH_HEAD_OK, PH_HEAD_BAD: begin
                    if (r_phase == PH_HEAD_OK && rx == i_cfg.head_second) begin
                        n_phase = PH_LEN;
                        n_pos   = '0;
                    end else begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_HEADER;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    if (r_pos == '0) begin
                        n_total = {rx, 8'h00};
                        n_pos   = 10'd1;
                    end else begin
                        n_total = {r_total[15:8], rx};
                        n_pos   = '0;
                        if (n_total < FRAME_OVH || n_total > TOTAL_MAX) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_LENGTH;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_phase = PH_CMD;
                        end
                    end
                end
                PH_CMD: begin
                    o_res_valid = 1'b1;
                    o_res       = '{kind: KIND_CMD, data: rx, status: ST_OK,
                                    plen: '0, done: 1'b0};
                    n_pos       = '0;
                    n_phase     = (psize == '0) ? PH_CRC : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_res_valid = 1'b1;
                    o_res       = '{kind: KIND_DATA, data: rx, status: ST_OK,
                                    plen: '0, done: 1'b0};
                    n_crc       = crc16_byte(r_crc, rx);
                    n_pos       = pos_inc;
                    if (pos_inc >= psize) begin
                        n_phase = PH_CRC;
                        n_pos   = '0;
                    end
                end
                PH_CRC: begin
                    if (r_pos == '0) begin
                        n_crc_hi = rx;
                        n_pos    = 10'd1;
                    end else begin
                        n_crc_bad = (r_crc[15:8] != r_crc_hi) || (r_crc[7:0] != rx);
                        n_phase   = PH_TAIL;
                        n_pos     = '0;
                    end
                end
                PH_TAIL: begin
                    if (r_pos == '0) begin
                        n_tail_ok = (rx == i_cfg.tail_first);
                        n_pos     = 10'd1;
                    end else begin
                        // crc error takes precedence over a tail error
                        n_pos       = '0;
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        o_res.plen  = psize;
                        if (r_crc_bad) begin
                            o_res.status = ST_CRC;
                        end else if (!r_tail_ok || rx != i_cfg.tail_second) begin
                            o_res.status = ST_TAIL;
                        end else begin
                            o_res.status = ST_OK;
                        end
                    end
                end
                default: ; // idle: drop stray bytes
            endcase
        end
    end

endmodule

// ===== rtl/core/crc16_checked_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// crc16_checked_frame_parser_unit
// Byte-serial frame parser: header, length, command, payload, CRC-16/MODBUS
// over the payload, tail. Passes command and payload bytes through and closes
// each frame with a status item.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    rx_byte[7:0], frame_start
//   o_out    out  valid/ready    out_kind[1:0], out_byte[7:0], status[2:0],
//                                payload_len[9:0], frame_done
//   i_cfg    in   valid/ready    index[7:0], data[7:0] (ready always high)
//
// One byte per cycle sustained while o_out accepts. A byte sits in the input
// register, then the parse logic and the byte-wide CRC update write the result
// register. Synchronous active-low reset clears the frame state and both valid
// flags, and loads the header/tail defaults. While o_out is stalled, the input
// register holds its byte and i_in.ready drops once it is full.
// ----------------------------------------------------------------------------
module crc16_checked_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crcfp_in_if.sink    i_in,
    crcfp_out_if.source o_out,
    crcfp_cfg_if.sink   i_cfg
);
    import crcfp_pkg::*;

    t_cfg     cfg;
    logic     item_valid;
    t_in_item item;
    logic     take;
    logic     res_valid;
    t_result  res;

    logic     r_out_valid;
    t_result  r_out;

    crcfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    crcfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    crcfp_parser u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // advance whenever the result register is free or being drained
    assign take = item_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_kind    = r_out.kind;
    assign o_out.out_byte    = r_out.data;
    assign o_out.status      = r_out.status;
    assign o_out.payload_len = r_out.plen;
    assign o_out.frame_done  = r_out.done;

    a_done_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.done == (r_out.kind == KIND_STATUS)))
        else $error("frame_done disagrees with item kind");

    a_byte_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_STATUS) |->
            (r_out.status == ST_OK && r_out.plen == '0))
        else $error("byte item carries status fields");

    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.plen <= PLEN_W'(MAX_PAYLOAD)))
        else $error("payload length above maximum");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result register changed while stalled");

endmodule

// ===== verif/crcfp_checker.sv =====
// ----------------------------------------------------------------------------
// crcfp_checker
// Watches the byte, result and register channels of the frame parser. Keeps
// its own copy of the parse state and registers, works out the results each
// received byte should cause, and compares every result transfer against
// the oldest outstanding one.
// ----------------------------------------------------------------------------
package crcfp_tb_pkg;

    // CRC-16/MODBUS: reflected, one byte folded in LSB first
    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

module crcfp_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    crcfp_in_if   in_ch,
    crcfp_out_if  out_ch,
    crcfp_cfg_if  cfg_ch,
    output int    o_fail_count,
    output int    o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import crcfp_pkg::*;
    import crcfp_tb_pkg::*;

    t_cfg        regs;
    t_phase      phase;
    logic [9:0]  pos;
    logic [15:0] total;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
    logic        crc_bad;
    logic        tail1_ok;
    t_result     results_due[$];
    int          mismatches = 0;

    function automatic logic [9:0] payload_count();
        return 10'(total - FRAME_OVH);
    endfunction

    task automatic close_frame(input t_status st, input logic [9:0] n);
        t_result r;
        r.kind   = KIND_STATUS;
        r.data   = 8'h00;
        r.status = st;
        r.plen   = n;
        r.done   = 1'b1;
        results_due.push_back(r);
        phase = PH_IDLE;
    endtask

    task automatic pass_byte(input t_kind k, input logic [7:0] b);
        t_result r;
        r.kind   = k;
        r.data   = b;
        r.status = ST_OK;
        r.plen   = '0;
        r.done   = 1'b0;
        results_due.push_back(r);
    endtask

    // advance the parse state by one received byte
    task automatic parse_byte(input logic [7:0] rx, input logic first_byte);
        logic [9:0] n;
        n = '0;
        if (first_byte) begin
            if (phase != PH_IDLE) begin
                // a new start cuts the open frame short
                case (phase)
                    PH_PAYLOAD:     n = pos;
                    PH_CRC, PH_TAIL: n = payload_count();
                    default:        n = '0;
                endcase
                close_frame(ST_LENGTH, n);
            end
            crc      = CRC_INIT;
            pos      = '0;
            total    = '0;
            crc_hi   = '0;
            crc_bad  = 1'b0;
            tail1_ok = 1'b0;
            phase    = (rx == regs.head_first) ? PH_HEAD_OK : PH_HEAD_BAD;
        end else begin
            case (phase)
                PH_HEAD_OK, PH_HEAD_BAD: begin
                    if (phase == PH_HEAD_OK && rx == regs.head_second) begin
                        phase = PH_LEN;
                        pos   = '0;
                    end else begin
                        close_frame(ST_HEADER, '0);
                    end
                end
                PH_LEN: begin
                    if (pos == 0) begin
                        total = {rx, 8'h00};
                        pos   = 10'd1;
                    end else begin
                        total = {total[15:8], rx};
                        pos   = '0;
                        if (total < FRAME_OVH || total > TOTAL_MAX) begin
                            close_frame(ST_LENGTH, '0);
                        end else begin
                            phase = PH_CMD;
                        end
                    end
                end
                PH_CMD: begin
                    pos   = '0;
                    phase = (payload_count() == 0) ? PH_CRC : PH_PAYLOAD;
                    pass_byte(KIND_CMD, rx);
                end
                PH_PAYLOAD: begin
                    crc = modbus_crc_next(crc, rx);
                    pos = pos + 10'd1;
                    if (pos >= payload_count()) begin
                        phase = PH_CRC;
                        pos   = '0;
                    end
                    pass_byte(KIND_DATA, rx);
                end
                PH_CRC: begin
                    if (pos == 0) begin
                        crc_hi = rx;
                        pos    = 10'd1;
                    end else begin
                        crc_bad = (crc[15:8] != crc_hi) || (crc[7:0] != rx);
                        phase   = PH_TAIL;
                        pos     = '0;
                    end
                end
                PH_TAIL: begin
                    if (pos == 0) begin
                        tail1_ok = (rx == regs.tail_first);
                        pos      = 10'd1;
                    end else begin
                        pos = '0;
                        // a CRC error wins over a tail error
                        if (crc_bad) begin
                            close_frame(ST_CRC, payload_count());
                        end else if (!tail1_ok || rx != regs.tail_second) begin
                            close_frame(ST_TAIL, payload_count());
                        end else begin
                            close_frame(ST_OK, payload_count());
                        end
                    end
                end
                default: begin
                    // idle: drop stray bytes
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            regs     = '{HEAD_RESET, HEAD_RESET, TAIL_RESET, TAIL_RESET};
            phase    = PH_IDLE;
            pos      = '0;
            total    = '0;
            crc      = CRC_INIT;
            crc_hi   = '0;
            crc_bad  = 1'b0;
            tail1_ok = 1'b0;
            results_due.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got kind=%0d byte=%02h",
                             $time, out_ch.out_kind, out_ch.out_byte,
                             " status=%0d len=%0d done=%0b",
                             out_ch.status, out_ch.payload_len, out_ch.frame_done);
                end else begin
                    want = results_due.pop_front();
                    if (out_ch.out_kind !== want.kind || out_ch.out_byte !== want.data ||
                        out_ch.status !== want.status ||
                        out_ch.payload_len !== want.plen ||
                        out_ch.frame_done !== want.done) begin
                        mismatches++;
                        $display("%0t: mismatch: expected kind=%0d byte=%02h status=%0d",
                                 $time, want.kind, want.data, want.status,
                                 " len=%0d done=%0b, got kind=%0d byte=%02h",
                                 want.plen, want.done, out_ch.out_kind, out_ch.out_byte,
                                 " status=%0d len=%0d done=%0b",
                                 out_ch.status, out_ch.payload_len, out_ch.frame_done);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_HEAD_FIRST:  regs.head_first  = cfg_ch.data;
                    CFG_HEAD_SECOND: regs.head_second = cfg_ch.data;
                    CFG_TAIL_FIRST:  regs.tail_first  = cfg_ch.data;
                    CFG_TAIL_SECOND: regs.tail_second = cfg_ch.data;
                    default: begin
                        // unknown index: no register changes
                    end
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                parse_byte(in_ch.rx_byte, in_ch.frame_start);
            end
        end
        o_results_due = results_due.size();
        o_fail_count  = mismatches;
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives received-byte streams into the CRC-16 checked frame parser: a short
// directed run on the reset registers, then random well-formed and broken
// frames under several register settings and idle/stall mixes. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import crcfp_pkg::*;
    import crcfp_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;

    typedef enum {
        FR_GOOD,
        FR_HEAD1,
        FR_HEAD2,
        FR_LEN,
        FR_CUT,
        FR_CRC,
        FR_TAIL1,
        FR_TAIL2,
        FR_CRC_TAIL,
        FR_STRAY
    } t_flaw;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int   fail_count;
    int   results_due;
    int   cycle_count = 0;
    int   src_idle    = 0;
    int   sink_stall  = 0;
    int   bytes_sent  = 0;
    t_cfg cur_cfg;

    crcfp_in_if  in_ch();
    crcfp_out_if out_ch();
    crcfp_cfg_if cfg_ch();

    crc16_checked_frame_parser_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    crcfp_checker i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_ch        (cfg_ch),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL crc16_checked_frame_parser_unit");
            $finish;
        end
    end

    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // one byte transfer; entered and left at a falling edge, valid held high
    task automatic put_byte(input logic [7:0] b, input logic first_byte);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= b;
        in_ch.frame_start <= first_byte;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input int n, input bit marked);
        for (int i = 0; i < n; i++) begin
            put_byte(seq[i], marked && i == 0);
        end
        if (marked) begin
            bytes_sent += n;
        end
    endtask

    // hold the input low until every result is back and the pipe is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_regs(input t_cfg c);
        logic [7:0] idx[5];
        logic [7:0] val[5];
        idx = '{8'($urandom_range(int'(CFG_TAIL_SECOND) + 1, 255)), CFG_HEAD_FIRST,
                CFG_HEAD_SECOND, CFG_TAIL_FIRST, CFG_TAIL_SECOND};
        val = '{8'($urandom), c.head_first, c.head_second, c.tail_first, c.tail_second};
        for (int i = 0; i < 5; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic send_frame(input t_flaw flaw, input int plen);
        logic [7:0]  fr[$];
        logic [15:0] total;
        logic [15:0] crc;
        logic [7:0]  b;
        int          keep;
        if (flaw == FR_STRAY) begin
            fr = {};
            repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom));
            send_bytes(fr, fr.size(), 1'b0);
            return;
        end
        total = 16'(plen + 9);
        if (flaw == FR_LEN) begin
            case ($urandom_range(2))
                0: total = 16'($urandom_range(0, int'(FRAME_OVH) - 1));
                1: total = 16'(int'(TOTAL_MAX) + $urandom_range(1, 64));
                default: total = 16'($urandom_range(int'(TOTAL_MAX) + 1, 16'hFFFF));
            endcase
        end
        crc = CRC_INIT;
        fr.push_back(cur_cfg.head_first);
        fr.push_back(cur_cfg.head_second);
        fr.push_back(total[15:8]);
        fr.push_back(total[7:0]);
        fr.push_back(8'($urandom));
        for (int i = 0; i < plen; i++) begin
            b   = 8'($urandom);
            crc = modbus_crc_next(crc, b);
            fr.push_back(b);
        end
        fr.push_back(crc[15:8]);
        fr.push_back(crc[7:0]);
        fr.push_back(cur_cfg.tail_first);
        fr.push_back(cur_cfg.tail_second);
        keep = fr.size();
        case (flaw)
            FR_HEAD1: begin
                fr[0] ^= 8'($urandom_range(1, 255));
                keep = 2;
            end
            FR_HEAD2: begin
                fr[1] ^= 8'($urandom_range(1, 255));
                keep = 2;
            end
            FR_LEN:   keep = 4;
            // the next frame's start closes this one
            FR_CUT:   keep = $urandom_range(1, fr.size() - 1);
            FR_CRC:   fr[5 + plen + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
            FR_TAIL1: fr[keep - 2] ^= 8'($urandom_range(1, 255));
            FR_TAIL2: fr[keep - 1] ^= 8'($urandom_range(1, 255));
            FR_CRC_TAIL: begin
                fr[5 + plen] ^= 8'(1 << $urandom_range(7));
                fr[keep - 1] ^= 8'($urandom_range(1, 255));
            end
            default: begin
            end
        endcase
        send_bytes(fr, keep, 1'b1);
    endtask

    task automatic random_frame();
        int    r;
        int    plen;
        t_flaw f;
        r    = $urandom_range(99);
        plen = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
        if (r < 58)      f = FR_GOOD;
        else if (r < 63) f = FR_HEAD1;
        else if (r < 68) f = FR_HEAD2;
        else if (r < 74) f = FR_LEN;
        else if (r < 82) f = FR_CUT;
        else if (r < 87) f = FR_CRC;
        else if (r < 91) f = FR_TAIL1;
        else if (r < 94) f = FR_TAIL2;
        else if (r < 97) f = FR_CRC_TAIL;
        else             f = FR_STRAY;
        send_frame(f, plen);
    endtask

    task automatic run_phase(input t_cfg c, input int idle, input int stall,
                             input int byte_goal, input bit longest);
        int base;
        load_regs(c);
        src_idle   = idle;
        sink_stall = stall;
        base       = bytes_sent;
        if (longest) begin
            send_frame(FR_GOOD, MAX_PAYLOAD);
        end
        while (bytes_sent - base < byte_goal) begin
            random_frame();
        end
        // end on a complete frame so the parser is idle for the next writes
        send_frame(FR_GOOD, $urandom_range(0, 12));
        settle();
    endtask

    initial begin : stimulus
        logic [7:0] seq[$];
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = '0;
        in_ch.frame_start = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        cur_cfg           = '{HEAD_RESET, HEAD_RESET, TAIL_RESET, TAIL_RESET};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values, no idling
        seq = {8'hFF};
        send_bytes(seq, 1, 1'b0);                   // stray byte while idle
        seq = {8'h00, 8'hFF};
        send_bytes(seq, 2, 1'b1);                   // wrong first header byte
        seq = {HEAD_RESET, HEAD_RESET, 8'h00, 8'h00};
        send_bytes(seq, 4, 1'b1);                   // total below the overhead
        seq = {HEAD_RESET, HEAD_RESET, 8'h00, 8'h09, 8'hFF, 8'hFF, 8'hFF,
               TAIL_RESET, TAIL_RESET};
        send_bytes(seq, 9, 1'b1);                   // empty payload, good
        seq = {HEAD_RESET, HEAD_RESET, 8'h02, 8'h09, 8'h00, 8'hFF, 8'h00};
        send_bytes(seq, 7, 1'b1);                   // largest total, cut short
        seq = {HEAD_RESET, HEAD_RESET, 8'h02, 8'h0A};
        send_bytes(seq, 4, 1'b1);                   // one above the largest total
        settle();

        run_phase('{8'h00, 8'hFF, 8'h00, 8'hFF}, 0, 0, 60, 1'b1);
        run_phase('{8'hFF, 8'h00, 8'hFF, 8'h00}, 79, 0, 80, 1'b0);
        run_phase('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)},
                  0, 79, 80, 1'b0);
        run_phase('{HEAD_RESET, HEAD_RESET, TAIL_RESET, TAIL_RESET}, 35, 35, 80, 1'b0);

        if (fail_count == 0) begin
            $display("PASS crc16_checked_frame_parser_unit");
        end else begin
            $display("FAIL crc16_checked_frame_parser_unit");
        end
        $finish;
    end

endmodule
